FILE: src/frpa_pkg.sv
package frpa_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CUT   = 2'd1;
	localparam logic [1:0] CMD_ALLOC = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;
	localparam logic [1:0] ST_NO_MEM  = 2'd3;

	localparam logic [31:0] RANGE_LIMIT = 32'hFFFFF000;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] add_base;
		logic [63:0] add_length;
		logic [31:0] cut_start;
		logic [31:0] cut_end;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] page_address;
		logic [4:0]  slots_used;
		logic [31:0] highest_end;
		logic [31:0] bytes_allocated;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_PREP,
		S_ADD_SCAN,
		S_CUT_PREP,
		S_CUT_RD,
		S_CUT_CHK,
		S_CUT_LO,
		S_CUT_HI,
		S_ALLOC_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        wr;
		logic [31:0] base;
		logic [31:0] len;
	} tbl_wr_t;

endpackage

FILE: src/frpa_table.sv
module frpa_table #(
	parameter int SLOTS = 16,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IW-1:0]         idx,
	input  frpa_pkg::tbl_wr_t     wr,
	output logic [31:0]           base,
	output logic [31:0]           len
);
	import frpa_pkg::*;

	logic [31:0] base_q [SLOTS];
	logic [31:0] len_q  [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				base_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else if (wr.wr) begin
			base_q[idx] <= wr.base;
			len_q[idx]  <= wr.len;
		end
	end

	assign base = base_q[idx];
	assign len  = len_q[idx];

endmodule

FILE: src/free_range_page_allocator.sv
// Free memory range allocator. Assert start while busy is low to issue one
// request; busy rises the next cycle and the result appears with done high
// for exactly one cycle, which the receiver must capture. The table is walked
// one slot at a time through a single slot port: add and alloc scans step one
// slot per cycle, while a cut reads, checks and splits each slot in its own states.
module free_range_page_allocator #(
	parameter int TABLE_SLOTS = 16,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  frpa_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output frpa_pkg::rsp_t  rsp
);
	import frpa_pkg::*;

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int PW = $clog2(PAGE_BYTES);
	localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
	localparam logic [32:0] PAGE33 = 33'(PAGE_BYTES);

	state_t state_q, state_n, ret_q;
	req_t req_q;
	logic [CW-1:0] m_q, cm_q, span_q;
	logic [31:0] hw_q, tot_q, page_q;
	logic [1:0] st_q;
	logic [32:0] ia_q, il_q;
	logic [32:0] s_q, e_q, lo_q, top_q, ss_q, se_q;
	logic [31:0] rb, rl;
	tbl_wr_t wr;
	logic [IW-1:0] idx;

	frpa_table #(.SLOTS(TABLE_SLOTS), .IW(IW)) u_tbl (
		.clk(clk), .arst_n(arst_n), .idx(idx), .wr(wr), .base(rb), .len(rl)
	);

	logic [63:0] a64, l64, room, lc;
	logic [32:0] ar, lr, hi;
	logic add_ign;
	always_comb begin
		a64 = (state_q == S_ADD_PREP && ret_q == S_IDLE) ? req_q.add_base : 64'(ia_q);
		l64 = (state_q == S_ADD_PREP && ret_q == S_IDLE) ? req_q.add_length : 64'(il_q);
		room = 64'(RANGE_LIMIT) - a64;
		lc = (l64 > room) ? room : l64;
		add_ign = (a64 > 64'(RANGE_LIMIT)) || (lc == '0);
		ar = (a64[PW-1:0] != '0) ? 33'({a64[32:PW], {PW{1'b0}}}) + PAGE33
			: 33'(a64[32:0]);
		lr = 33'({lc[32:PW], {PW{1'b0}}});
		hi = ia_q + il_q;
	end

	logic cut_scan_end, alloc_end;
	assign cut_scan_end = (cm_q >= span_q) || (cm_q >= SLOTS_C);
	assign alloc_end = cut_scan_end;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				unique case (req.command)
					CMD_ADD:   state_n = S_ADD_PREP;
					CMD_CUT:   state_n = S_CUT_PREP;
					CMD_ALLOC: state_n = S_ALLOC_SCAN;
					default:   state_n = S_DONE;
				endcase
			end
			S_ADD_PREP: state_n = add_ign ? ret_q == S_IDLE ? S_DONE : ret_q : S_ADD_SCAN;
			S_ADD_SCAN:
				if (rl == '0) state_n = (ret_q == S_IDLE) ? S_DONE : ret_q;
				else if (m_q == SLOTS_C - 1'b1) state_n = S_DONE;
			S_CUT_PREP: state_n = S_CUT_RD;
			S_CUT_RD: state_n = cut_scan_end ? S_DONE : S_CUT_CHK;
			S_CUT_CHK: state_n = (ss_q >= se_q) ? S_CUT_RD : S_CUT_LO;
			S_CUT_LO: state_n = (ss_q > lo_q) ? S_ADD_PREP : S_CUT_HI;
			S_CUT_HI: state_n = (se_q < top_q) ? S_ADD_PREP : S_CUT_RD;
			S_ALLOC_SCAN:
				if (alloc_end || rl != '0) state_n = S_DONE;
			S_DONE: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		idx = '0;
		wr = '0;
		unique case (state_q)
			S_ADD_SCAN: begin
				idx = m_q[IW-1:0];
				wr.wr = (rl == '0);
				wr.base = ia_q[31:0];
				wr.len = il_q[31:0];
			end
			S_CUT_RD, S_CUT_CHK: idx = cm_q[IW-1:0];
			S_CUT_LO: begin
				idx = cm_q[IW-1:0];
				wr.wr = 1'b1;
			end
			S_ALLOC_SCAN: begin
				idx = cm_q[IW-1:0];
				wr.wr = !alloc_end && rl != '0;
				wr.base = rb + 32'(PAGE_BYTES);
				wr.len = (rl < 32'(PAGE_BYTES)) ? '0 : rl - 32'(PAGE_BYTES);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			span_q <= '0;
			hw_q <= '0;
			tot_q <= '0;
			st_q <= ST_OK;
			m_q <= '0;
			cm_q <= '0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				S_IDLE: if (start) begin
					ret_q <= S_IDLE;
					st_q <= (req.command == CMD_ADD || req.command == CMD_CUT
						|| req.command == CMD_ALLOC) ? ST_OK : ST_IGNORED;
					cm_q <= '0;
				end
				S_ADD_PREP: begin
					m_q <= '0;
					if (add_ign) begin
						if (ret_q == S_IDLE) st_q <= ST_IGNORED;
					end
					ia_q <= ar;
					il_q <= lr;
				end
				S_ADD_SCAN:
					if (rl == '0) begin
						if (m_q >= span_q) span_q <= m_q + 1'b1;
						if (hi[32]) hw_q <= '1;
						else if (hi[31:0] > hw_q) hw_q <= hi[31:0];
					end else if (m_q == SLOTS_C - 1'b1) begin
						st_q <= ST_NO_SLOT;
					end else begin
						m_q <= m_q + 1'b1;
					end
				S_CUT_PREP: begin
					s_q <= {1'b0, req_q.cut_start[31:PW], {PW{1'b0}}};
					e_q <= (req_q.cut_end[PW-1:0] != '0)
						? {1'b0, req_q.cut_end[31:PW], {PW{1'b0}}} + PAGE33
						: {1'b0, req_q.cut_end};
				end
				S_CUT_RD: begin
					lo_q <= {1'b0, rb};
					top_q <= {1'b0, rb} + {1'b0, rl};
					ss_q <= (s_q < {1'b0, rb}) ? {1'b0, rb} : s_q;
					se_q <= (e_q > {1'b0, rb} + {1'b0, rl}) ? {1'b0, rb} + {1'b0, rl} : e_q;
				end
				S_CUT_CHK: if (ss_q >= se_q) cm_q <= cm_q + 1'b1;
				S_CUT_LO: if (ss_q > lo_q) begin
					ret_q <= S_CUT_HI;
					ia_q <= lo_q;
					il_q <= ss_q - lo_q;
				end
				S_CUT_HI: begin
					if (se_q < top_q) begin
						ret_q <= S_CUT_RD;
						ia_q <= se_q;
						il_q <= top_q - se_q;
					end
					if (!(se_q < top_q)) cm_q <= cm_q + 1'b1;
				end
				S_ALLOC_SCAN:
					if (alloc_end) begin
						st_q <= ST_NO_MEM;
					end else if (rl != '0) begin
						tot_q <= tot_q + 32'(PAGE_BYTES);
					end else begin
						cm_q <= cm_q + 1'b1;
					end
				default: ;
			endcase
			if (state_q == S_ADD_PREP && ret_q == S_CUT_RD && state_n == S_CUT_RD)
				cm_q <= cm_q + 1'b1;
			if (state_q == S_ADD_SCAN && rl == '0 && ret_q == S_CUT_RD)
				cm_q <= cm_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			page_q <= '0;
		end
		if (state_q == S_ALLOC_SCAN && !alloc_end && rl != '0) page_q <= rb;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp.status = st_q;
	assign rsp.page_address = page_q;
	assign rsp.slots_used = 5'(span_q);
	assign rsp.highest_end = hw_q;
	assign rsp.bytes_allocated = tot_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		span_q <= SLOTS_C) else $error("span overflow");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("done not followed by idle");

endmodule
